// ----- hw/rtl/rpmt_pkg.sv -----
// ============================================================================
// rpmt_pkg
// Shared types and constants for the refcounted page map table.
// ============================================================================
`default_nettype none

package rpmt_pkg;

    // Field widths of the request and response transfers
    localparam int CMD_W        = 1;
    localparam int GPN_W        = 20;
    localparam int STATUS_W     = 3;
    localparam int SLOT_W       = 4;
    localparam int REFS_W       = 16;
    localparam int BASE_W       = 32;

    localparam logic [REFS_W-1:0] REFS_MAX = '1;

    // Request commands
    localparam logic [CMD_W-1:0] CMD_MAP   = 1'b0;
    localparam logic [CMD_W-1:0] CMD_UNMAP = 1'b1;

    // Response status codes
    typedef enum logic [STATUS_W-1:0] {
        RSP_HIT  = 3'd0,
        RSP_NEW  = 3'd1,
        RSP_FULL = 3'd2,
        RSP_DEC  = 3'd3,
        RSP_FREE = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic load;     // latch request, restart the scan
        logic scan_rd;  // issue one table read, advance the scan pointer
        logic commit;   // write table update, load the response register
    } t_ctl_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic scan_last;  // read of the last slot is being issued
        logic out_free;   // response register can take a new result
    } t_ctl_sts;

endpackage

`default_nettype wire

// ----- hw/rtl/rpmt_intf.sv -----
// ============================================================================
// rpmt_intf
// Valid/ready channel interfaces for requests and responses.
// ============================================================================
`default_nettype none

interface rpmt_req_if import rpmt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [GPN_W-1:0] gpn;

    modport source (output valid, cmd, gpn, input ready);
    modport sink   (input valid, cmd, gpn, output ready);
endinterface

interface rpmt_rsp_if import rpmt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                not_found;
    logic [SLOT_W-1:0]   slot;
    logic [REFS_W-1:0]   ref_count;
    logic [BASE_W-1:0]   base_addr;

    modport source (output valid, status, not_found, slot, ref_count, base_addr,
                    input ready);
    modport sink   (input valid, status, not_found, slot, ref_count, base_addr,
                    output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/rpmt_ram.sv -----
// ============================================================================
// rpmt_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module rpmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/rpmt_ctrl.sv -----
// ============================================================================
// rpmt_ctrl
// Sequencer: accept, scan all slots, drain last compare, commit result.
// ============================================================================
`default_nettype none

module rpmt_ctrl import rpmt_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_ctl_sts i_sts,
    output t_ctl_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_sts.scan_last) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.scan_rd = 1'b0;
        o_cmd.commit  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_COMMIT: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

    a_commit_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> r_state == ST_IDLE)
        else $error("commit did not return to idle");

    a_drain_to_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DRAIN |=> r_state == ST_COMMIT)
        else $error("drain did not advance to commit");

    a_scan_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) && !i_sts.scan_last |=> r_state == ST_SCAN)
        else $error("scan ended before the last slot");

endmodule

`default_nettype wire

// ----- hw/rtl/rpmt_dp.sv -----
// ============================================================================
// rpmt_dp
// Table storage, scan compare, update logic and response register.
// ============================================================================
`default_nettype none

module rpmt_dp import rpmt_pkg::*; #(
    parameter int ENTRIES    = 16,
    parameter int PAGE_SIZE  = 4096,
    parameter int INDEX_BITS = 20
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_ctl_cmd                i_cmd,
    output t_ctl_sts                     o_sts,
    input  wire logic [CMD_W-1:0]        i_in_cmd,
    input  wire logic [GPN_W-1:0]        i_in_gpn,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic [STATUS_W-1:0]          o_out_status,
    output logic                         o_out_not_found,
    output logic [SLOT_W-1:0]            o_out_slot,
    output logic [REFS_W-1:0]            o_out_ref_count,
    output logic [BASE_W-1:0]            o_out_base_addr
);

    localparam int IW = (INDEX_BITS < GPN_W) ? INDEX_BITS : GPN_W;
    localparam int AW = $clog2(ENTRIES);
    localparam int PW = $clog2(PAGE_SIZE) + 1;
    localparam int MW = IW + PW;

    // Request and scan state
    logic [CMD_W-1:0]   r_cmd;
    logic [IW-1:0]      r_idx;
    logic [AW-1:0]      r_cnt;
    logic               r_cmp_vld;
    logic [AW-1:0]      r_cmp_slot;
    logic               r_found;
    logic [AW-1:0]      r_slot;
    logic [REFS_W-1:0]  r_refs;
    logic               r_free_found;
    logic [AW-1:0]      r_free_slot;
    logic [ENTRIES-1:0] r_valid;

    // Response register
    logic                r_out_vld;
    logic [STATUS_W-1:0] r_status;
    logic                r_nf;
    logic [SLOT_W-1:0]   r_oslot;
    logic [REFS_W-1:0]   r_orefs;
    logic [BASE_W-1:0]   r_obase;

    logic [IW-1:0]     w_idx_rd;
    logic [REFS_W-1:0] w_refs_rd;
    logic              w_valid_rd;
    logic              w_match;
    logic              w_empty;
    logic [MW-1:0]     w_prod;
    logic [REFS_W-1:0] w_inc;

    t_status           c_status;
    logic              c_nf;
    logic [AW-1:0]     c_slot;
    logic [REFS_W-1:0] c_refs;
    logic              c_report;
    logic              c_set_valid;
    logic              c_clr_valid;
    logic              c_idx_we;
    logic              c_refs_we;

    rpmt_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_idx_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && c_idx_we),
        .i_waddr (c_slot),
        .i_wdata (r_idx),
        .i_raddr (r_cnt),
        .o_rdata (w_idx_rd)
    );

    rpmt_ram #(.WIDTH(REFS_W), .DEPTH(ENTRIES)) u_refs_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && c_refs_we),
        .i_waddr (c_slot),
        .i_wdata (c_refs),
        .i_raddr (r_cnt),
        .o_rdata (w_refs_rd)
    );

    // Compare stage works on the registered read data and the registered slot address
    assign w_valid_rd = r_valid[r_cmp_slot];
    assign w_match    = r_cmp_vld && w_valid_rd && (w_idx_rd == r_idx);
    assign w_empty    = r_cmp_vld && !w_valid_rd;

    assign o_sts.scan_last = (r_cnt == AW'(ENTRIES - 1));
    assign o_sts.out_free  = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld    <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_rd;
            if (i_cmd.load) begin
                r_found      <= 1'b0;
                r_free_found <= 1'b0;
            end else begin
                if (w_match) r_found <= 1'b1;
                if (w_empty) r_free_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_slot <= r_cnt;
        if (i_cmd.load) begin
            r_cmd <= i_in_cmd;
            r_idx <= i_in_gpn[IW-1:0];
            r_cnt <= '0;
        end else begin
            if (i_cmd.scan_rd) r_cnt <= r_cnt + AW'(1);
            // keep only the lowest-numbered hit and free slot
            if (w_match && !r_found) begin
                r_slot <= r_cmp_slot;
                r_refs <= w_refs_rd;
            end
            if (w_empty && !r_free_found) r_free_slot <= r_cmp_slot;
        end
    end

    assign w_inc  = (r_refs == REFS_MAX) ? r_refs : r_refs + REFS_W'(1);
    assign w_prod = MW'(r_idx) * MW'(PAGE_SIZE);

    always_comb begin
        c_status    = RSP_FULL;
        c_nf        = 1'b0;
        c_slot      = '0;
        c_refs      = '0;
        c_report    = 1'b0;
        c_set_valid = 1'b0;
        c_clr_valid = 1'b0;
        c_idx_we    = 1'b0;
        c_refs_we   = 1'b0;
        case (r_cmd)
            CMD_MAP: begin
                if (r_found) begin
                    c_status  = RSP_HIT;
                    c_slot    = r_slot;
                    c_refs    = w_inc;
                    c_refs_we = 1'b1;
                    c_report  = 1'b1;
                end else if (r_free_found) begin
                    c_status    = RSP_NEW;
                    c_slot      = r_free_slot;
                    c_refs      = REFS_W'(1);
                    c_refs_we   = 1'b1;
                    c_idx_we    = 1'b1;
                    c_set_valid = 1'b1;
                    c_report    = 1'b1;
                end
            end
            CMD_UNMAP: begin
                if (!r_found) begin
                    c_status = RSP_FREE;
                    c_nf     = 1'b1;
                end else if (r_refs > REFS_W'(1)) begin
                    c_status  = RSP_DEC;
                    c_slot    = r_slot;
                    c_refs    = r_refs - REFS_W'(1);
                    c_refs_we = 1'b1;
                    c_report  = 1'b1;
                end else begin
                    c_status    = RSP_FREE;
                    c_slot      = r_slot;
                    c_clr_valid = 1'b1;
                    c_report    = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.commit) begin
            if (c_set_valid) r_valid[c_slot] <= 1'b1;
            if (c_clr_valid) r_valid[c_slot] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status <= c_status;
            r_nf     <= c_nf;
            r_oslot  <= SLOT_W'(c_slot);
            r_orefs  <= c_refs;
            r_obase  <= c_report ? BASE_W'(w_prod) : '0;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_out_status     = r_status;
    assign o_out_not_found  = r_nf;
    assign o_out_slot       = r_oslot;
    assign o_out_ref_count  = r_orefs;
    assign o_out_base_addr  = r_obase;

    a_commit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_vld)
        else $error("commit did not load the response register");

    a_hit_is_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && r_found |-> r_valid[r_slot])
        else $error("matched slot is not valid");

    a_alloc_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && c_idx_we |-> !r_valid[c_slot])
        else $error("allocation into an occupied slot");

    a_load_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_cnt == '0) && !r_found && !r_free_found)
        else $error("scan state not cleared on request");

endmodule

`default_nettype wire

// ----- hw/rtl/refcounted_page_map_table.sv -----
// ============================================================================
// refcounted_page_map_table
// Each request is accepted in idle; a sequential scan then reads every slot
// of the table, the last compare drains, and the update commits, loading the
// response register once it is free; a new request is taken only after that.
// The response register lets a new request start while a result waits.
// Reset clears all slot valid bits at once; no clearing pass is needed.
// ============================================================================
`default_nettype none

module refcounted_page_map_table import rpmt_pkg::*; #(
    parameter int ENTRIES    = 16,
    parameter int PAGE_SIZE  = 4096,
    parameter int INDEX_BITS = 20
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rpmt_req_if.sink    i_req,
    rpmt_rsp_if.source  o_rsp
);

    t_ctl_cmd w_cmd;
    t_ctl_sts w_sts;
    logic     w_in_ready;

    assign i_req.ready = w_in_ready;

    rpmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rpmt_dp #(
        .ENTRIES    (ENTRIES),
        .PAGE_SIZE  (PAGE_SIZE),
        .INDEX_BITS (INDEX_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_in_cmd         (i_req.cmd),
        .i_in_gpn         (i_req.gpn),
        .o_out_valid      (o_rsp.valid),
        .i_out_ready      (o_rsp.ready),
        .o_out_status     (o_rsp.status),
        .o_out_not_found  (o_rsp.not_found),
        .o_out_slot       (o_rsp.slot),
        .o_out_ref_count  (o_rsp.ref_count),
        .o_out_base_addr  (o_rsp.base_addr)
    );

endmodule

`default_nettype wire
